>>> rtl/core/hdr_pkg.sv
// hdr_pkg: shared types, codes and constants of the heading dead reckoning core
// no dependencies

package hdr_pkg;

   localparam int unsigned MAG_W = 24;
   localparam int unsigned POS_W = 32;
   localparam int unsigned HEAD_W = 17;
   localparam int unsigned TRIG_W = 32;
   localparam int unsigned ANG_W = 25;
   localparam int unsigned MAX_STEPS = 24;

   localparam int unsigned FULL_TURN = 92160;
   localparam int unsigned HALF_TURN = 46080;
   localparam int unsigned QUARTER_TURN = 23040;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;

   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_TURN = 2'd2;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   localparam logic [1:0] UNIT_METRE = 2'd0;
   localparam logic [1:0] UNIT_CENTIMETRE = 2'd1;

   typedef struct packed {
      logic [1:0] operation;
      logic signed [MAG_W-1:0] magnitude;
      logic [1:0] unit;
      logic [HEAD_W-1:0] heading;
   } cmd_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] unit;
      logic neg;
   } ctl_type;

   // arctangent of 2^-i in degrees * 2^16
   function automatic logic [21:0] atan_entry(input logic [4:0] idx);
      logic [21:0] val;
      unique case (idx)
         5'd0: val = 22'd2949120;
         5'd1: val = 22'd1740967;
         5'd2: val = 22'd919879;
         5'd3: val = 22'd466945;
         5'd4: val = 22'd234379;
         5'd5: val = 22'd117304;
         5'd6: val = 22'd58666;
         5'd7: val = 22'd29335;
         5'd8: val = 22'd14668;
         5'd9: val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         5'd18: val = 22'd14;
         5'd19: val = 22'd7;
         5'd20: val = 22'd4;
         5'd21: val = 22'd2;
         5'd22: val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/core/hdr_front.sv
// hdr_front: accepts command items, reduces turn angles modulo a full turn
// and tracks the heading; depends on hdr_pkg

module hdr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic signed [23:0]   req_magnitude,
   input  logic [1:0]           req_unit,
   output logic                 push_valid,
   output hdr_pkg::cmd_type     push_cmd,
   input  logic                 queue_full
);
   import hdr_pkg::*;

   localparam logic [14:0] RECIP_45 = 15'd23302;
   localparam logic [13:0] HI_OFFSET = 14'd4140;

   logic                     advance;
   logic                     s1_valid_ff;
   logic [1:0]               s1_op_ff;
   logic signed [MAG_W-1:0]  s1_mag_ff;
   logic [1:0]               s1_unit_ff;
   logic                     s2_valid_ff;
   logic [1:0]               s2_op_ff;
   logic signed [MAG_W-1:0]  s2_mag_ff;
   logic [1:0]               s2_unit_ff;
   logic [13:0]              s2_u_ff;
   logic [7:0]               s2_q_ff;
   logic                     s3_valid_ff;
   logic [1:0]               s3_op_ff;
   logic signed [MAG_W-1:0]  s3_mag_ff;
   logic [1:0]               s3_unit_ff;
   logic [HEAD_W-1:0]        s3_turn_ff;
   logic [HEAD_W-1:0]        heading_ff;
   logic [HEAD_W-1:0]        heading_in;
   logic [13:0]              s1_u;
   logic [28:0]              s1_prod;
   logic [13:0]              s2_q45;
   logic [13:0]              s2_rem;
   logic [17:0]              head_sum;
   logic [17:0]              head_wrap;

   assign advance = !s3_valid_ff || !queue_full;
   assign req_stall = !advance;

   // upper bits of the angle, offset by a multiple of 45 to stay positive
   assign s1_u = 14'({s1_mag_ff[23], s1_mag_ff[23:11]}) + HI_OFFSET;
   assign s1_prod = 29'(s1_u) * 29'(RECIP_45);

   assign s2_q45 = {1'b0, s2_q_ff, 5'b0} + {3'b0, s2_q_ff, 3'b0}
                 + {4'b0, s2_q_ff, 2'b0} + {6'b0, s2_q_ff};
   assign s2_rem = s2_u_ff - s2_q45;

   assign head_sum = {1'b0, heading_ff} + {1'b0, s3_turn_ff};
   assign head_wrap = (head_sum >= 18'(FULL_TURN)) ? head_sum - 18'(FULL_TURN) : head_sum;

   always_comb begin
      heading_in = heading_ff;
      if (push_valid) begin
         unique case (s3_op_ff)
            OP_RESTART: heading_in = '0;
            OP_TURN: heading_in = head_wrap[HEAD_W-1:0];
            OP_ADVANCE, OP_UNKNOWN: heading_in = heading_ff;
            default: heading_in = heading_ff;
         endcase
      end
   end

   assign push_valid = s3_valid_ff && !queue_full;
   assign push_cmd = '{operation: s3_op_ff, magnitude: s3_mag_ff, unit: s3_unit_ff,
                       heading: heading_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         heading_ff <= '0;
      end else begin
         heading_ff <= heading_in;
         if (advance) begin
            s1_valid_ff <= req_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff <= req_operation;
         s1_mag_ff <= req_magnitude;
         s1_unit_ff <= req_unit;
         s2_op_ff <= s1_op_ff;
         s2_mag_ff <= s1_mag_ff;
         s2_unit_ff <= s1_unit_ff;
         s2_u_ff <= s1_u;
         s2_q_ff <= s1_prod[27:20];
         s3_op_ff <= s2_op_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_unit_ff <= s2_unit_ff;
         s3_turn_ff <= {s2_rem[5:0], s2_mag_ff[10:0]};
      end
   end

endmodule

>>> rtl/core/hdr_queue.sv
// hdr_queue: short command queue between the front and back parts
// depends on hdr_pkg

module hdr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  hdr_pkg::cmd_type     push_cmd,
   output logic                 queue_full,
   input  logic                 pop,
   output hdr_pkg::cmd_type     head_cmd,
   output logic                 queue_empty
);
   import hdr_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff;

   assign queue_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/hdr_back.sv
// hdr_back: pipelined cordic rotation, scaling with rounding and saturating
// position accumulation with the result register; depends on hdr_pkg

module hdr_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [31:0]      start_x,
   input  logic signed [31:0]      start_y,
   input  hdr_pkg::cmd_type        head_cmd,
   input  logic                    queue_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic                    rsp_bad_command
);
   import hdr_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > int'(MAX_STEPS)) ? int'(MAX_STEPS) : CORDIC_STEPS;
   localparam logic [25:0] RECIP_100 = 26'd42949673;
   localparam logic [55:0] HALF_ONE = 56'd536870912;
   localparam logic signed [32:0] POS_MAX = 33'sd2147483647;
   localparam logic signed [32:0] POS_MIN = -33'sd2147483648;

   logic back_en;

   // cordic stages
   logic                       cv_ff  [STEPS+1];
   ctl_type                    ctl_ff [STEPS+1];
   logic signed [MAG_W-1:0]    mag_ff [STEPS+1];
   logic signed [TRIG_W-1:0]   x_ff   [STEPS+1];
   logic signed [TRIG_W-1:0]   y_ff   [STEPS+1];
   logic signed [ANG_W-1:0]    z_ff   [STEPS+1];

   // scaling stages
   logic                       p1_valid_ff;
   ctl_type                    p1_ctl_ff;
   logic signed [55:0]         px_ff;
   logic signed [55:0]         py_ff;
   logic                       p2_valid_ff;
   ctl_type                    p2_ctl_ff;
   logic                       p2_sx_ff;
   logic                       p2_sy_ff;
   logic [25:0]                p2_vx_ff;
   logic [25:0]                p2_vy_ff;
   logic                       p3_valid_ff;
   ctl_type                    p3_ctl_ff;
   logic                       p3_sx_ff;
   logic                       p3_sy_ff;
   logic [25:0]                p3_vx_ff;
   logic [25:0]                p3_vy_ff;

   logic                       rsp_valid_ff;
   logic signed [POS_W-1:0]    cur_x_ff;
   logic signed [POS_W-1:0]    cur_y_ff;
   logic                       bad_ff;

   logic signed [17:0]         h_wrap;
   logic signed [17:0]         h_red;
   logic                       h_neg;
   logic [55:0]                ax;
   logic [55:0]                ay;
   logic [25:0]                pre_x;
   logic [25:0]                pre_y;
   logic [51:0]                cm_x;
   logic [51:0]                cm_y;
   logic signed [26:0]         dx;
   logic signed [26:0]         dy;
   logic signed [32:0]         sum_x;
   logic signed [32:0]         sum_y;
   logic signed [POS_W-1:0]    sat_x;
   logic signed [POS_W-1:0]    sat_y;

   assign back_en = !rsp_valid_ff || !rsp_stall;
   assign pop = back_en && !queue_empty;

   // heading into [-90, 90] degrees, with a flip of the result beyond
   always_comb begin
      if (head_cmd.heading >= HEAD_W'(HALF_TURN)) begin
         h_wrap = $signed({1'b0, head_cmd.heading}) - 18'sd92160;
      end else begin
         h_wrap = $signed({1'b0, head_cmd.heading});
      end
      h_red = h_wrap;
      h_neg = 1'b0;
      if (h_wrap > $signed(18'(QUARTER_TURN))) begin
         h_red = h_wrap - $signed(18'(HALF_TURN));
         h_neg = 1'b1;
      end else if (h_wrap < -$signed(18'(QUARTER_TURN))) begin
         h_red = h_wrap + $signed(18'(HALF_TURN));
         h_neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (back_en) begin
         cv_ff[0] <= !queue_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         ctl_ff[0] <= '{operation: head_cmd.operation, unit: head_cmd.unit, neg: h_neg};
         mag_ff[0] <= head_cmd.magnitude;
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({h_red[16:0], 8'b0});
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      logic signed [ANG_W-1:0] atan_val;
      assign atan_val = $signed({3'b0, atan_entry(5'(i))});

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (back_en) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (back_en) begin
            ctl_ff[i+1] <= ctl_ff[i];
            mag_ff[i+1] <= mag_ff[i];
            if (!z_ff[i][ANG_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_val;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_val;
            end
         end
      end
   end

   // magnitude of product, then rounded scaling to metres
   assign ax = px_ff[55] ? 56'(-px_ff) : 56'(px_ff);
   assign ay = py_ff[55] ? 56'(-py_ff) : 56'(py_ff);
   assign pre_x = (p1_ctl_ff.unit == UNIT_CENTIMETRE) ? ax[55:30] + 26'd50
                                                      : 26'((ax + HALF_ONE) >> 30);
   assign pre_y = (p1_ctl_ff.unit == UNIT_CENTIMETRE) ? ay[55:30] + 26'd50
                                                      : 26'((ay + HALF_ONE) >> 30);
   assign cm_x = 52'(p2_vx_ff) * 52'(RECIP_100);
   assign cm_y = 52'(p2_vy_ff) * 52'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (back_en) begin
         p1_valid_ff <= cv_ff[STEPS];
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         p1_ctl_ff <= ctl_ff[STEPS];
         px_ff <= 56'(mag_ff[STEPS] * x_ff[STEPS]);
         py_ff <= 56'(mag_ff[STEPS] * y_ff[STEPS]);
         p2_ctl_ff <= p1_ctl_ff;
         p2_sx_ff <= px_ff[55] ^ p1_ctl_ff.neg;
         p2_sy_ff <= py_ff[55] ^ p1_ctl_ff.neg;
         p2_vx_ff <= pre_x;
         p2_vy_ff <= pre_y;
         p3_ctl_ff <= p2_ctl_ff;
         p3_sx_ff <= p2_sx_ff;
         p3_sy_ff <= p2_sy_ff;
         p3_vx_ff <= (p2_ctl_ff.unit == UNIT_CENTIMETRE) ? 26'(cm_x[51:32]) : p2_vx_ff;
         p3_vy_ff <= (p2_ctl_ff.unit == UNIT_CENTIMETRE) ? 26'(cm_y[51:32]) : p2_vy_ff;
      end
   end

   // accumulate with saturation
   assign dx = p3_sx_ff ? -$signed({1'b0, p3_vx_ff}) : $signed({1'b0, p3_vx_ff});
   assign dy = p3_sy_ff ? -$signed({1'b0, p3_vy_ff}) : $signed({1'b0, p3_vy_ff});
   assign sum_x = 33'(cur_x_ff) + 33'(dx);
   assign sum_y = 33'(cur_y_ff) + 33'(dy);
   assign sat_x = (sum_x > POS_MAX) ? POS_MAX[31:0] :
                  (sum_x < POS_MIN) ? POS_MIN[31:0] : sum_x[31:0];
   assign sat_y = (sum_y > POS_MAX) ? POS_MAX[31:0] :
                  (sum_y < POS_MIN) ? POS_MIN[31:0] : sum_y[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         bad_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= p3_valid_ff;
         if (p3_valid_ff) begin
            bad_ff <= (p3_ctl_ff.operation == OP_UNKNOWN);
            unique case (p3_ctl_ff.operation)
               OP_RESTART: begin
                  cur_x_ff <= start_x;
                  cur_y_ff <= start_y;
               end
               OP_ADVANCE: begin
                  if (p3_ctl_ff.unit == UNIT_METRE || p3_ctl_ff.unit == UNIT_CENTIMETRE) begin
                     cur_x_ff <= sat_x;
                     cur_y_ff <= sat_y;
                  end
               end
               OP_TURN, OP_UNKNOWN: begin
                  cur_x_ff <= cur_x_ff;
                  cur_y_ff <= cur_y_ff;
               end
               default: begin
                  cur_x_ff <= cur_x_ff;
                  cur_y_ff <= cur_y_ff;
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = cur_x_ff;
   assign rsp_pos_y = cur_y_ff;
   assign rsp_bad_command = bad_ff;

endmodule

>>> rtl/core/heading_dead_reckoning_core.sv
// heading_dead_reckoning_core: top level with start position registers
// depends on hdr_pkg, hdr_front, hdr_queue, hdr_back
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_stall  operation, magnitude, unit
//   rsp_        out        rsp_valid/rsp_stall  pos_x, pos_y, bad_command
//   csr_        in/out     apb r/w, pready=1    start_x at 0, start_y at 4
//
// one item per cycle sustained unless rsp_stall or a full queue holds the flow;
// the path runs through three front stages, the queue entry register, a load stage,
// one cordic stage per step and four scaling and accumulation stages
// synchronous active high reset clears the heading, the position and the queue
// rsp_stall holds the back pipeline; a four-item queue lets the front keep going

module heading_dead_reckoning_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic signed [23:0]   req_magnitude,
   input  logic [1:0]           req_unit,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic                 rsp_bad_command,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import hdr_pkg::*;

   localparam logic REG_START_X = 1'b0;
   localparam logic REG_START_Y = 1'b1;

   logic signed [POS_W-1:0] start_x_ff;
   logic signed [POS_W-1:0] start_y_ff;
   logic                    csr_write;
   logic                    push_valid;
   cmd_type                 push_cmd;
   cmd_type                 head_cmd;
   logic                    queue_full;
   logic                    queue_empty;
   logic                    pop;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_START_X: start_x_ff <= csr_pwdata;
            REG_START_Y: start_y_ff <= csr_pwdata;
            default: start_x_ff <= start_x_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_START_X: csr_prdata = start_x_ff;
         REG_START_Y: csr_prdata = start_y_ff;
         default: csr_prdata = '0;
      endcase
   end

   hdr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_magnitude (req_magnitude),
      .req_unit      (req_unit),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .queue_full    (queue_full)
   );

   hdr_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full),
      .pop         (pop),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty)
   );

   hdr_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .start_x         (start_x_ff),
      .start_y         (start_y_ff),
      .head_cmd        (head_cmd),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_bad_command (rsp_bad_command)
   );

endmodule

>>> bench/tb_heading_dead_reckoning_core.sv
// testbench for heading_dead_reckoning_core: directed probes, then random motion commands
// checked against a cycle-free pose tracker with its own cordic; depends on hdr_pkg and the rtl

module tb_heading_dead_reckoning_core;
   timeunit 1ns;
   timeprecision 1ps;

   import hdr_pkg::*;

   localparam int TRACK_STEPS = 16;

   localparam longint DEG_FULL = 92160;
   localparam longint DEG_HALF = 46080;
   localparam longint DEG_QUARTER = 23040;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint Q30_ONE = 1073741824;
   localparam longint POS_TOP = 64'sd2147483647;
   localparam longint POS_BOTTOM = -64'sd2147483648;

   localparam longint ATAN_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   localparam logic [1:0] UNIT_OTHER = 2'd2;
   localparam logic [1:0] UNIT_SPARE = 2'd3;

   localparam logic [2:0] ADDR_START_X = 3'd0;
   localparam logic [2:0] ADDR_START_Y = 3'd4;

   localparam logic signed [23:0] MAG_TOP = 24'sh7fffff;
   localparam logic signed [23:0] MAG_BOTTOM = 24'sh800000;
   localparam logic signed [23:0] MAG_QUARTER = 24'sd23040;

   localparam logic signed [31:0] PROBE_X = 32'sh7fffff00;
   localparam logic signed [31:0] PROBE_Y = 32'sh80000000;

   typedef struct packed {
      logic [1:0] op;
      logic signed [23:0] mag;
      logic [1:0] unit;
   } motion_cmd_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic bad;
   } pose_type;

   typedef struct packed {
      motion_cmd_type cmd;
      logic typed;
      pose_type pose;
   } probe_row_type;

   localparam pose_type NO_POSE = '0;
   localparam int PROBE_ROWS = 22;

   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{'{OP_UNKNOWN, 24'sd0, UNIT_METRE}, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
      '{'{OP_ADVANCE, 24'sd256, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_RESTART, -24'sd1, UNIT_SPARE}, 1'b1, '{PROBE_X, PROBE_Y, 1'b0}},
      '{'{OP_ADVANCE, MAG_TOP, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_TURN, MAG_QUARTER, UNIT_SPARE}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, MAG_BOTTOM, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_TURN, MAG_QUARTER, UNIT_OTHER}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, MAG_TOP, UNIT_CENTIMETRE}, 1'b0, NO_POSE},
      '{'{OP_TURN, MAG_BOTTOM, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, MAG_TOP, UNIT_OTHER}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, MAG_BOTTOM, UNIT_SPARE}, 1'b0, NO_POSE},
      '{'{OP_TURN, MAG_TOP, UNIT_CENTIMETRE}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, -24'sd1, UNIT_CENTIMETRE}, 1'b0, NO_POSE},
      '{'{OP_RESTART, MAG_TOP, UNIT_METRE}, 1'b1, '{PROBE_X, PROBE_Y, 1'b0}},
      '{'{OP_TURN, -MAG_QUARTER, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, MAG_TOP, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_TURN, 24'sd46079, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, 24'sd65536, UNIT_CENTIMETRE}, 1'b0, NO_POSE},
      '{'{OP_TURN, 24'sd1, UNIT_OTHER}, 1'b0, NO_POSE},
      '{'{OP_UNKNOWN, MAG_TOP, UNIT_SPARE}, 1'b0, NO_POSE},
      '{'{OP_ADVANCE, 24'sd0, UNIT_METRE}, 1'b0, NO_POSE},
      '{'{OP_RESTART, MAG_BOTTOM, UNIT_CENTIMETRE}, 1'b1, '{PROBE_X, PROBE_Y, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = OP_RESTART;
   logic signed [23:0] req_magnitude = '0;
   logic [1:0] req_unit = UNIT_METRE;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic rsp_bad_command;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic signed [31:0] start_x_reg = '0;
   logic signed [31:0] start_y_reg = '0;
   longint track_x = 0;
   longint track_y = 0;
   longint track_head = 0;

   pose_type pose_q [$];
   bit calm = 1'b0;
   int rsp_hold = 0;
   int fails = 0;
   int sent = 0;
   int checked = 0;
   int op_seen [4] = '{0, 0, 0, 0};

   heading_dead_reckoning_core #(.CORDIC_STEPS(TRACK_STEPS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_magnitude(req_magnitude),
      .req_unit(req_unit),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_bad_command(rsp_bad_command),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic void heading_trig(input longint head, output longint cos_q,
                                        output longint sin_q);
      longint ang, x, y, z, nx;
      logic flip;
      int steps, i;
      ang = head;
      flip = 1'b0;
      steps = (TRACK_STEPS > 24) ? 24 : TRACK_STEPS;
      if (ang >= DEG_HALF) ang -= DEG_FULL;
      if (ang > DEG_QUARTER) begin
         ang -= DEG_HALF;
         flip = 1'b1;
      end else if (ang < -DEG_QUARTER) begin
         ang += DEG_HALF;
         flip = 1'b1;
      end
      x = GAIN_Q30;
      y = 0;
      z = ang * 256;
      for (i = 0; i < steps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_Q16[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_Q16[i];
         end
         x = nx;
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
   endfunction

   // nearest, ties away from zero
   function automatic longint round_div(input longint num, input longint den);
      longint num_abs, q;
      num_abs = (num < 0) ? -num : num;
      q = (num_abs + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > POS_TOP) return POS_TOP;
      if (v < POS_BOTTOM) return POS_BOTTOM;
      return v;
   endfunction

   function automatic pose_type track_cmd(input motion_cmd_type c);
      pose_type p;
      longint cq, sq, den, span, t;
      p.bad = 1'b0;
      span = longint'($signed(c.mag));
      case (c.op)
         OP_RESTART: begin
            track_x = start_x_reg;
            track_y = start_y_reg;
            track_head = 0;
         end
         OP_ADVANCE: begin
            if (c.unit == UNIT_METRE || c.unit == UNIT_CENTIMETRE) begin
               den = (c.unit == UNIT_METRE) ? Q30_ONE : 100 * Q30_ONE;
               heading_trig(track_head, cq, sq);
               track_x = clamp32(track_x + round_div(span * cq, den));
               track_y = clamp32(track_y + round_div(span * sq, den));
            end
         end
         OP_TURN: begin
            t = (track_head + span) % DEG_FULL;
            if (t < 0) t += DEG_FULL;
            track_head = t;
         end
         default: p.bad = 1'b1;
      endcase
      p.x = track_x[31:0];
      p.y = track_y[31:0];
      return p;
   endfunction

   function automatic motion_cmd_type random_cmd();
      motion_cmd_type c;
      int pick;
      pick = $urandom_range(0, 99);
      c.op = (pick < 8) ? OP_RESTART : (pick < 55) ? OP_ADVANCE :
             (pick < 94) ? OP_TURN : OP_UNKNOWN;
      case ($urandom_range(0, 4))
         0: c.mag = 24'($urandom);
         1: c.mag = 24'($urandom_range(0, 2 * 23040) - 23040);
         2: c.mag = 24'(($urandom_range(0, 8) - 4) * 23040);
         3: begin
            case ($urandom_range(0, 3))
               0: c.mag = MAG_TOP;
               1: c.mag = MAG_BOTTOM;
               2: c.mag = 24'sd0;
               default: c.mag = -24'sd1;
            endcase
         end
         default: c.mag = 24'($urandom_range(0, 4095) - 2048);
      endcase
      pick = $urandom_range(0, 99);
      c.unit = (pick < 45) ? UNIT_METRE : (pick < 85) ? UNIT_CENTIMETRE :
               (pick < 93) ? UNIT_OTHER : UNIT_SPARE;
      return c;
   endfunction

   task automatic send_cmd(input motion_cmd_type c, input logic typed,
                           input pose_type typed_pose);
      int gap;
      pose_type p;
      gap = idle_draw();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= c.op;
      req_magnitude <= c.mag;
      req_unit <= c.unit;
      do @(posedge clock); while (req_stall);
      p = track_cmd(c);
      pose_q.insert(pose_q.size(), typed ? typed_pose : p);
      sent++;
      op_seen[c.op]++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_START_X) start_x_reg = data;
      else start_y_reg = data;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== data) begin
         $error("csr_prdata at %0d expected %h got %h", addr, data, csr_prdata);
         fails++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_start(input logic [31:0] sx, input logic [31:0] sy);
      csr_write(ADDR_START_X, sx);
      csr_write(ADDR_START_Y, sy);
   endtask

   always @(posedge clock) begin
      pose_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (pose_q.size() == 0) begin
               $error("unexpected item: pos_x %0d pos_y %0d bad_command %0b",
                      rsp_pos_x, rsp_pos_y, rsp_bad_command);
               fails++;
            end else begin
               want = pose_q.pop_front();
               if (rsp_pos_x !== want.x) begin
                  $error("pos_x expected %0d got %0d", want.x, rsp_pos_x);
                  fails++;
               end
               if (rsp_pos_y !== want.y) begin
                  $error("pos_y expected %0d got %0d", want.y, rsp_pos_y);
                  fails++;
               end
               if (rsp_bad_command !== want.bad) begin
                  $error("bad_command expected %0b got %0b", want.bad, rsp_bad_command);
                  fails++;
               end
            end
            rsp_hold = idle_draw();
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_hold != 0);
   end

   initial begin
      int phase, n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_start(PROBE_X, PROBE_Y);
      for (n = 0; n < PROBE_ROWS; n++) begin
         send_cmd(probe_rows[n].cmd, probe_rows[n].typed, probe_rows[n].pose);
      end
      for (phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: set_start(32'h0000_0000, 32'h0000_0000);
            1: set_start(32'h7fff_ffff, 32'h8000_0000);
            2: set_start(32'h8000_0000, 32'h7fff_ffff);
            default: set_start($urandom, $urandom);
         endcase
         for (n = 0; n < 125; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            send_cmd(random_cmd(), 1'b0, NO_POSE);
         end
      end
      settle();
      repeat (TRACK_STEPS + 12) @(posedge clock);
      $display("%0d commands sent: %0d restarts, %0d advances, %0d turns, %0d unknown",
               sent, op_seen[OP_RESTART], op_seen[OP_ADVANCE], op_seen[OP_TURN],
               op_seen[OP_UNKNOWN]);
      $display("%0d poses compared over five start positions, %0d mismatches", checked, fails);
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d poses outstanding", pose_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/hdr_pkg.sv
rtl/core/hdr_front.sv
rtl/core/hdr_queue.sv
rtl/core/hdr_back.sv
rtl/core/heading_dead_reckoning_core.sv
bench/tb_heading_dead_reckoning_core.sv
